// ----- src/rs3n_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs3n_pkg
// Types, widths and helpers for the 3-D nearest-neighbor resampling
// index generator.
// ----------------------------------------------------------------------------
package rs3n_pkg;

    localparam int unsigned MAX_DIM   = 4096;
    localparam int unsigned FRAC_W    = 16;                   // ratio fraction bits
    localparam int unsigned COORD_W   = $clog2(MAX_DIM);      // 12
    localparam int unsigned DIM_W     = $clog2(MAX_DIM) + 1;  // 13
    localparam int unsigned RATIO_W   = 24;
    localparam int unsigned IDX_W     = 36;
    localparam int unsigned PROD_W    = COORD_W + RATIO_W;    // scaled coordinate
    localparam int unsigned SCL_W     = PROD_W - FRAC_W;      // floored coordinate
    localparam int unsigned AREA_W    = 2 * COORD_W + 1;      // dim_x * dim_y
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO_X   = 3'd0,
        CFG_RATIO_Y   = 3'd1,
        CFG_RATIO_Z   = 3'd2,
        CFG_SRC_DIM_X = 3'd3,
        CFG_SRC_DIM_Y = 3'd4,
        CFG_SRC_DIM_Z = 3'd5,
        CFG_DST_DIM_X = 3'd6,
        CFG_DST_DIM_Y = 3'd7
    } t_cfg_idx;

    // Working configuration, dimensions already limited to 1..MAX_DIM
    typedef struct packed {
        logic [RATIO_W-1:0] ratio_x;
        logic [RATIO_W-1:0] ratio_y;
        logic [RATIO_W-1:0] ratio_z;
        logic [DIM_W-1:0]   src_x;
        logic [DIM_W-1:0]   src_y;
        logic [DIM_W-1:0]   src_z;
        logic [DIM_W-1:0]   dst_x;
        logic [DIM_W-1:0]   dst_y;
    } t_cfg;

    // Payload between the scale and index sections
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] plane;
        logic               hit;
        logic [AREA_W-1:0]  src_area;   // src_y * src_x
        logic [IDX_W-1:0]   dst_plane;  // dst_z * dim_x * dim_y
        logic [AREA_W-1:0]  dst_row;    // dst_y * dim_x + dst_x
    } t_mid;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = d;
        end
        return r;
    endfunction

endpackage

// ----- src/rs3n_pix_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs3n_pix_if
// Destination voxel coordinate channel.
// ----------------------------------------------------------------------------
interface rs3n_pix_if;
    logic                            valid;
    logic                            ready;
    logic [rs3n_pkg::COORD_W-1:0]    dst_x;
    logic [rs3n_pkg::COORD_W-1:0]    dst_y;
    logic [rs3n_pkg::COORD_W-1:0]    dst_z;

    modport source (output valid, output dst_x, output dst_y, output dst_z, input ready);
    modport sink   (input valid, input dst_x, input dst_y, input dst_z, output ready);
endinterface

// ----- src/rs3n_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs3n_res_if
// Source / destination index result channel.
// ----------------------------------------------------------------------------
interface rs3n_res_if;
    logic                          valid;
    logic                          ready;
    logic [rs3n_pkg::IDX_W-1:0]    source_index;
    logic [rs3n_pkg::IDX_W-1:0]    dest_index;
    logic                          out_of_range;

    modport source (output valid, output source_index, output dest_index,
                    output out_of_range, input ready);
    modport sink   (input valid, input source_index, input dest_index,
                    input out_of_range, output ready);
endinterface

// ----- src/rs3n_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs3n_scale
// Stages 1-2: coordinate times ratio, floor, clamp to source size; the
// destination row/plane products start here too.
// ----------------------------------------------------------------------------
module rs3n_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rs3n_pkg::t_cfg       i_cfg,
    rs3n_pix_if.sink             i_pix,
    output logic                 o_mid_valid,
    input  logic                 i_mid_ready,
    output rs3n_pkg::t_mid       o_mid
);

    localparam int unsigned CW = rs3n_pkg::COORD_W;
    localparam int unsigned PW = rs3n_pkg::PROD_W;
    localparam int unsigned SW = rs3n_pkg::SCL_W;
    localparam int unsigned AW = rs3n_pkg::AREA_W;
    localparam int unsigned DW = rs3n_pkg::DIM_W;
    localparam int unsigned IW = rs3n_pkg::IDX_W;
    localparam int unsigned FW = rs3n_pkg::FRAC_W;

    // stage 1
    logic          r_s1_v;
    logic [PW-1:0] r_s1_px, r_s1_py, r_s1_pz;
    logic [AW-1:0] r_s1_dyx, r_s1_dzx;
    logic [CW-1:0] r_s1_x;
    // stage 2
    logic          r_s2_v;
    rs3n_pkg::t_mid r_s2_mid;

    logic adv1, adv2;
    logic [PW-1:0] n_px, n_py, n_pz;
    logic [AW-1:0] n_dyx, n_dzx;
    rs3n_pkg::t_mid n_mid;
    logic hit_x, hit_y, hit_z;
    logic [SW-1:0] sx, sy, sz;

    assign adv2        = !r_s2_v || i_mid_ready;
    assign adv1        = !r_s1_v || adv2;
    assign i_pix.ready = adv1;
    assign o_mid_valid = r_s2_v;
    assign o_mid       = r_s2_mid;

    always_comb begin
        n_px  = PW'(i_pix.dst_x) * PW'(i_cfg.ratio_x);
        n_py  = PW'(i_pix.dst_y) * PW'(i_cfg.ratio_y);
        n_pz  = PW'(i_pix.dst_z) * PW'(i_cfg.ratio_z);
        n_dyx = AW'(i_pix.dst_y) * AW'(i_cfg.dst_x);
        n_dzx = AW'(i_pix.dst_z) * AW'(i_cfg.dst_x);
    end

    // floor by dropping the fraction, then clamp to dim-1
    always_comb begin
        sx    = r_s1_px[PW-1:FW];
        sy    = r_s1_py[PW-1:FW];
        sz    = r_s1_pz[PW-1:FW];
        hit_x = sx >= SW'(i_cfg.src_x);
        hit_y = sy >= SW'(i_cfg.src_y);
        hit_z = sz >= SW'(i_cfg.src_z);
        n_mid.col       = hit_x ? CW'(i_cfg.src_x - DW'(1)) : sx[CW-1:0];
        n_mid.row       = hit_y ? CW'(i_cfg.src_y - DW'(1)) : sy[CW-1:0];
        n_mid.plane     = hit_z ? CW'(i_cfg.src_z - DW'(1)) : sz[CW-1:0];
        n_mid.hit       = hit_x || hit_y || hit_z;
        n_mid.src_area  = AW'(i_cfg.src_y) * AW'(i_cfg.src_x);
        n_mid.dst_plane = IW'(r_s1_dzx) * IW'(i_cfg.dst_y);
        n_mid.dst_row   = r_s1_dyx + AW'(r_s1_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_v <= i_pix.valid;
            end
            if (adv2) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_px  <= n_px;
            r_s1_py  <= n_py;
            r_s1_pz  <= n_pz;
            r_s1_dyx <= n_dyx;
            r_s1_dzx <= n_dzx;
            r_s1_x   <= i_pix.dst_x;
        end
        if (adv2) begin
            r_s2_mid <= n_mid;
        end
    end

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (DW'(r_s2_mid.col) < i_cfg.src_x))
        else $error("clamped column beyond source width");
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (DW'(r_s2_mid.row) < i_cfg.src_y))
        else $error("clamped row beyond source height");
    a_plane_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (DW'(r_s2_mid.plane) < i_cfg.src_z))
        else $error("clamped plane beyond source depth");

endmodule

// ----- src/rs3n_index.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs3n_index
// Stages 3-4: linearize source and destination coordinates; stage 4 is the
// output register.
// ----------------------------------------------------------------------------
module rs3n_index (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rs3n_pkg::t_cfg       i_cfg,
    input  logic                 i_mid_valid,
    output logic                 o_mid_ready,
    input  rs3n_pkg::t_mid       i_mid,
    rs3n_res_if.source           o_res
);

    localparam int unsigned AW = rs3n_pkg::AREA_W;
    localparam int unsigned IW = rs3n_pkg::IDX_W;

    logic          r_s3_v, r_s4_v;
    logic [IW-1:0] r_s3_src_pl, r_s3_dst;
    logic [AW-1:0] r_s3_src_rc;
    logic          r_s3_hit;
    logic [IW-1:0] r_s4_src, r_s4_dst;
    logic          r_s4_hit;

    logic          adv3, adv4;
    logic [IW-1:0] n_src_pl, n_dst, n_src;
    logic [AW-1:0] n_src_rc;

    assign adv4        = !r_s4_v || o_res.ready;
    assign adv3        = !r_s3_v || adv4;
    assign o_mid_ready = adv3;

    assign o_res.valid        = r_s4_v;
    assign o_res.source_index = r_s4_src;
    assign o_res.dest_index   = r_s4_dst;
    assign o_res.out_of_range = r_s4_hit;

    always_comb begin
        n_src_pl = IW'(i_mid.plane) * IW'(i_mid.src_area);
        n_src_rc = AW'(i_mid.row) * AW'(i_cfg.src_x) + AW'(i_mid.col);
        n_dst    = i_mid.dst_plane + IW'(i_mid.dst_row);
        n_src    = r_s3_src_pl + IW'(r_s3_src_rc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (adv3) begin
                r_s3_v <= i_mid_valid;
            end
            if (adv4) begin
                r_s4_v <= r_s3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_s3_src_pl <= n_src_pl;
            r_s3_src_rc <= n_src_rc;
            r_s3_dst    <= n_dst;
            r_s3_hit    <= i_mid.hit;
        end
        if (adv4) begin
            r_s4_src <= n_src;
            r_s4_dst <= r_s3_dst;
            r_s4_hit <= r_s3_hit;
        end
    end

    // a held stage-3 item must still be there next cycle
    a_stage3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_v && !adv4) |=> (r_s3_v && $stable(r_s3_dst)))
        else $error("stage 3 item lost during stall");

endmodule

// ----- src/resample_3d_nearest_index.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resample_3d_nearest_index
// Nearest-neighbor 3-D resampling address generator: destination voxel in,
// linear source and destination voxel indices out.
//
//   channel   dir  handshake        payload
//   i_pix     in   valid/ready      dst_x, dst_y, dst_z (12b each)
//   o_res     out  valid/ready      source_index, dest_index (36b), out_of_range
//   i_cfg_*   in   write enable     i_cfg_idx (3b), i_cfg_data (24b)
//
// One transfer per cycle sustained while o_res is ready; the result passes through
// four pipeline registers (scale, clamp, linearize, sum/output).
// Synchronous active-low reset empties the pipeline and restores ratios 1.0
// and all dimensions 1.
// A stall on o_res holds the whole pipe; bubbles ahead of the stalled stage
// still fill, so i_pix can keep transferring until every stage is full.
// ----------------------------------------------------------------------------
module resample_3d_nearest_index (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rs3n_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rs3n_pkg::RATIO_W-1:0]       i_cfg_data,
    rs3n_pix_if.sink                           i_pix,
    rs3n_res_if.source                         o_res
);

    localparam int unsigned RW = rs3n_pkg::RATIO_W;
    localparam int unsigned DW = rs3n_pkg::DIM_W;

    logic [RW-1:0] r_ratio_x, r_ratio_y, r_ratio_z;
    logic [DW-1:0] r_src_x, r_src_y, r_src_z, r_dst_x, r_dst_y;

    rs3n_pkg::t_cfg cfg;
    rs3n_pkg::t_mid mid;
    logic           mid_valid, mid_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_x <= RW'(1) << rs3n_pkg::FRAC_W;
            r_ratio_y <= RW'(1) << rs3n_pkg::FRAC_W;
            r_ratio_z <= RW'(1) << rs3n_pkg::FRAC_W;
            r_src_x   <= DW'(1);
            r_src_y   <= DW'(1);
            r_src_z   <= DW'(1);
            r_dst_x   <= DW'(1);
            r_dst_y   <= DW'(1);
        end else if (i_cfg_we) begin
            case (rs3n_pkg::t_cfg_idx'(i_cfg_idx))
                rs3n_pkg::CFG_RATIO_X:   r_ratio_x <= i_cfg_data;
                rs3n_pkg::CFG_RATIO_Y:   r_ratio_y <= i_cfg_data;
                rs3n_pkg::CFG_RATIO_Z:   r_ratio_z <= i_cfg_data;
                rs3n_pkg::CFG_SRC_DIM_X: r_src_x   <= i_cfg_data[DW-1:0];
                rs3n_pkg::CFG_SRC_DIM_Y: r_src_y   <= i_cfg_data[DW-1:0];
                rs3n_pkg::CFG_SRC_DIM_Z: r_src_z   <= i_cfg_data[DW-1:0];
                rs3n_pkg::CFG_DST_DIM_X: r_dst_x   <= i_cfg_data[DW-1:0];
                rs3n_pkg::CFG_DST_DIM_Y: r_dst_y   <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // zero dimension acts as 1, oversized as MAX_DIM
    always_comb begin
        cfg.ratio_x = r_ratio_x;
        cfg.ratio_y = r_ratio_y;
        cfg.ratio_z = r_ratio_z;
        cfg.src_x   = rs3n_pkg::eff_dim(r_src_x);
        cfg.src_y   = rs3n_pkg::eff_dim(r_src_y);
        cfg.src_z   = rs3n_pkg::eff_dim(r_src_z);
        cfg.dst_x   = rs3n_pkg::eff_dim(r_dst_x);
        cfg.dst_y   = rs3n_pkg::eff_dim(r_dst_y);
    end

    rs3n_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pix       (i_pix),
        .o_mid_valid (mid_valid),
        .i_mid_ready (mid_ready),
        .o_mid       (mid)
    );

    rs3n_index u_index (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_mid_valid (mid_valid),
        .o_mid_ready (mid_ready),
        .i_mid       (mid),
        .o_res       (o_res)
    );

endmodule
